[sv/lphsc_pkg.sv]
// Shared constants and request codes for the linear probing hash subset check unit.
package lphsc_pkg;

  localparam int unsigned TABLE_SLOTS = 16384;
  localparam int unsigned SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_BITS    = 31;
  localparam int unsigned REQ_BITS    = 2;

  // Input tdata carries the key padded to whole bytes.
  localparam int unsigned IN_DATA_BITS  = ((KEY_BITS + 7) / 8) * 8;
  // Output tdata carries found, stored and subset_holds padded to one byte.
  localparam int unsigned OUT_DATA_BITS = 8;

  // Memory word: the valid flag above the key.
  localparam int unsigned WORD_BITS = KEY_BITS + 1;

  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_QUERY  = 2'd2;

endpackage

[sv/linear_probe_hash_subset_check_unit.sv]
// Top level: open-addressing hash table with linear probing used as a subset tester.
//
// Input words arrive on in_tvalid/in_tready with the key in in_tdata, the request
// kind (clear, insert, query) in in_tuser and the list-end mark in in_tlast.
// Every input word yields exactly one result word on out_tvalid/out_tready:
// found, stored and the running subset flag in out_tdata, the echoed mark in
// out_tlast.
// Slots live in a single-port-write memory with a registered read; the probe
// sequencer visits one slot per cycle. An insert or query probes from one slot
// (an empty home slot) up to all 16384 slots (a full table) before its result
// is ready. A clear sweeps every slot, one per cycle; an unused request code
// goes straight to its result. in_tready rises as the result is loaded into
// the output register, so a word is accepted only once the previous word's
// result is loaded.
// After reset the same sweep runs before in_tready first rises.
// The result sits in an output register, so the next word may be accepted while
// the receiver stalls; the sequencer waits only when it has a new result and the
// output register is still full.
module linear_probe_hash_subset_check_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [lphsc_pkg::IN_DATA_BITS-1:0]     in_tdata,  // [30:0] key, rest zero
  input  logic [lphsc_pkg::REQ_BITS-1:0]         in_tuser,  // [1:0] req_type
  input  logic                                   in_tlast,  // last_item
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [lphsc_pkg::OUT_DATA_BITS-1:0]    out_tdata, // [0] found, [1] stored,
                                                            // [2] subset_holds, rest zero
  output logic                                   out_tlast  // list_done
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

  state_t                              state_r;
  logic [lphsc_pkg::SLOT_BITS-1:0]     slot_r;
  logic [lphsc_pkg::SLOT_BITS-1:0]     count_r;
  logic [lphsc_pkg::KEY_BITS-1:0]      key_r;
  logic [lphsc_pkg::REQ_BITS-1:0]      req_r;
  logic                                last_r;
  logic                                sweep_item_r;
  logic                                all_found_r;
  logic                                res_found_r;
  logic                                res_stored_r;
  logic                                out_tvalid_r;
  logic                                out_found_r;
  logic                                out_stored_r;
  logic                                out_subset_r;
  logic                                out_last_r;

  // Slot memory and its port signals.
  logic [lphsc_pkg::WORD_BITS-1:0]     slot_mem [lphsc_pkg::TABLE_SLOTS];
  logic [lphsc_pkg::WORD_BITS-1:0]     rd_data_r;
  logic [lphsc_pkg::SLOT_BITS-1:0]     rd_addr;
  logic [lphsc_pkg::SLOT_BITS-1:0]     wr_addr;
  logic [lphsc_pkg::WORD_BITS-1:0]     wr_data;
  logic                                wr_en;

  logic [lphsc_pkg::KEY_BITS-1:0]      in_key;
  logic [lphsc_pkg::SLOT_BITS-1:0]     in_home;
  logic [lphsc_pkg::SLOT_BITS-1:0]     slot_next;
  logic                                slot_valid;
  logic                                key_match;
  logic                                in_accept;
  logic                                out_free;
  logic                                out_load;
  logic                                probe_last;

  assign in_key     = in_tdata[lphsc_pkg::KEY_BITS-1:0];
  assign in_home    = in_key[lphsc_pkg::SLOT_BITS-1:0];
  assign slot_next  = slot_r + 1'b1;
  assign slot_valid = rd_data_r[lphsc_pkg::KEY_BITS];
  assign key_match  = (rd_data_r[lphsc_pkg::KEY_BITS-1:0] == key_r);
  assign probe_last = (count_r == {lphsc_pkg::SLOT_BITS{1'b1}});
  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_load   = (state_r == ST_DONE) && out_free;

  // While probing, the next slot is read so that one slot is checked per cycle.
  always_comb begin
    if (state_r == ST_PROBE) begin
      rd_addr = slot_next;
    end else begin
      rd_addr = in_home;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = {1'b1, key_r};
    case (state_r)
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_PROBE: begin
        wr_en = (req_r == lphsc_pkg::REQ_INSERT) && !slot_valid;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      slot_r       <= '0;
      count_r      <= '0;
      sweep_item_r <= 1'b0;
      all_found_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_SWEEP: begin
          slot_r <= slot_next;
          if (slot_r == {lphsc_pkg::SLOT_BITS{1'b1}}) begin
            if (sweep_item_r) begin
              all_found_r  <= 1'b1;
              res_found_r  <= 1'b0;
              res_stored_r <= 1'b0;
              state_r      <= ST_DONE;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            key_r        <= in_key;
            req_r        <= in_tuser;
            last_r       <= in_tlast;
            count_r      <= '0;
            res_found_r  <= 1'b0;
            res_stored_r <= 1'b0;
            case (in_tuser)
              lphsc_pkg::REQ_CLEAR: begin
                slot_r       <= '0;
                sweep_item_r <= 1'b1;
                state_r      <= ST_SWEEP;
              end
              lphsc_pkg::REQ_INSERT, lphsc_pkg::REQ_QUERY: begin
                slot_r  <= in_home;
                state_r <= ST_PROBE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_PROBE: begin
          if (!slot_valid) begin
            // An empty slot ends both an insert (placed here) and a query (miss).
            if (req_r == lphsc_pkg::REQ_INSERT) begin
              res_stored_r <= 1'b1;
            end else begin
              all_found_r <= 1'b0;
            end
            state_r <= ST_DONE;
          end else if ((req_r == lphsc_pkg::REQ_QUERY) && key_match) begin
            res_found_r <= 1'b1;
            state_r     <= ST_DONE;
          end else if (probe_last) begin
            // Every slot visited: the table is full or the key is absent.
            if (req_r == lphsc_pkg::REQ_QUERY) begin
              all_found_r <= 1'b0;
            end
            state_r <= ST_DONE;
          end else begin
            slot_r  <= slot_next;
            count_r <= count_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_found_r  <= res_found_r;
            out_stored_r <= res_stored_r;
            out_subset_r <= all_found_r;
            out_last_r   <= last_r;
            sweep_item_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(lphsc_pkg::OUT_DATA_BITS-3){1'b0}},
                       out_subset_r, out_stored_r, out_found_r};
  assign out_tlast  = out_last_r;

endmodule

[dv/subset_probe_checker.sv]
// Checker that mirrors the probing hash table, predicts every result word and compares it.
module subset_probe_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [lphsc_pkg::IN_DATA_BITS-1:0]  in_tdata,  // [30:0] key, rest zero
  input  logic [lphsc_pkg::REQ_BITS-1:0]      in_tuser,  // [1:0] req_type
  input  logic                                in_tlast,  // last_item
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [lphsc_pkg::OUT_DATA_BITS-1:0] out_tdata, // [0] found, [1] stored,
                                                         // [2] subset_holds
  input  logic                                out_tlast, // list_done
  output int unsigned                         mismatches,
  output int unsigned                         results_due
);

  typedef logic [lphsc_pkg::KEY_BITS-1:0]  key_t;
  typedef logic [lphsc_pkg::SLOT_BITS-1:0] slot_t;

  typedef struct packed {
    logic found;
    logic stored;
    logic subset_holds;
    logic list_done;
  } outcome_t;

  key_t                slot_key  [lphsc_pkg::TABLE_SLOTS];
  bit                  slot_used [lphsc_pkg::TABLE_SLOTS];
  bit                  every_query_hit;
  outcome_t            outcome_q [$];

  function automatic logic place_key(input key_t key);
    slot_t s;
    s = slot_t'(key % lphsc_pkg::TABLE_SLOTS);
    for (int unsigned n = 0; n < lphsc_pkg::TABLE_SLOTS; n++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        slot_key[s]  = key;
        return 1'b1;
      end
      s = (s == slot_t'(lphsc_pkg::TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic look_up(input key_t key);
    slot_t s;
    s = slot_t'(key % lphsc_pkg::TABLE_SLOTS);
    for (int unsigned n = 0; n < lphsc_pkg::TABLE_SLOTS; n++) begin
      if (!slot_used[s]) return 1'b0;
      if (slot_key[s] == key) return 1'b1;
      s = (s == slot_t'(lphsc_pkg::TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t predict_outcome(input logic [lphsc_pkg::REQ_BITS-1:0] req,
                                               input key_t key,
                                               input logic last);
    outcome_t o;
    o = '0;
    case (req)
      lphsc_pkg::REQ_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        every_query_hit = 1'b1;
      end
      lphsc_pkg::REQ_INSERT: o.stored = place_key(key);
      lphsc_pkg::REQ_QUERY: begin
        o.found = look_up(key);
        if (!o.found) every_query_hit = 1'b0;
      end
      default: ;
    endcase
    o.subset_holds = every_query_hit;
    o.list_done    = last;
    return o;
  endfunction

  task automatic report_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      every_query_hit = 1'b1;
      mismatches      = 0;
      outcome_q.delete();
    end else begin
      // Input side first, so a word accepted on this edge is already queued.
      if (in_tvalid && in_tready)
        outcome_q.push_back(predict_outcome(in_tuser, in_tdata[lphsc_pkg::KEY_BITS-1:0],
                                            in_tlast));
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual tdata=%0h tlast=%0b",
                   $time, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          report_field("found", want.found, out_tdata[0]);
          report_field("stored", want.stored, out_tdata[1]);
          report_field("subset_holds", want.subset_holds, out_tdata[2]);
          report_field("list_done", want.list_done, out_tlast);
        end
      end
    end
    results_due = outcome_q.size();
  end

endmodule

[dv/tb_top.sv]
// Testbench top: drives clears, insert lists, query lists and spare request codes into the hash subset unit.
module tb_top;

  typedef logic [lphsc_pkg::KEY_BITS-1:0]  key_t;
  typedef logic [lphsc_pkg::SLOT_BITS-1:0] slot_t;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned IDLE_PCT     = 9;
  localparam int unsigned LIVE_DEPTH   = 64;
  localparam int unsigned CHAIN_WORDS  = 40;
  localparam logic [lphsc_pkg::REQ_BITS-1:0] REQ_SPARE = 2'd3;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [lphsc_pkg::IN_DATA_BITS-1:0]  in_tdata;  // [30:0] key, rest zero
  logic [lphsc_pkg::REQ_BITS-1:0]      in_tuser;  // [1:0] req_type
  logic                                in_tlast;  // last_item
  logic                                out_tvalid;
  logic                                out_tready;
  logic [lphsc_pkg::OUT_DATA_BITS-1:0] out_tdata; // [0] found, [1] stored, [2] subset_holds
  logic                                out_tlast; // list_done

  int unsigned         mismatches;
  int unsigned         results_due;
  int unsigned         random_words;
  int unsigned         cycles;
  bit                  calm;
  slot_t               cluster_home;
  key_t                live_keys [$];

  linear_probe_hash_subset_check_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  subset_probe_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [lphsc_pkg::REQ_BITS-1:0] req, input key_t key,
                           input logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {{(lphsc_pkg::IN_DATA_BITS - lphsc_pkg::KEY_BITS){1'b0}}, key};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drain();
    while (results_due != 0) @(negedge clk);
  endtask

  // Mix of wide random keys, keys clustered around one home slot and keys seen recently.
  function automatic key_t pick_key(input int unsigned live_pct);
    key_t k;
    k = key_t'($urandom);
    if (live_keys.size() != 0 && $urandom_range(0, 99) < live_pct)
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
    else if ($urandom_range(0, 99) < 60)
      k[lphsc_pkg::SLOT_BITS-1:0] = slot_t'(cluster_home + $urandom_range(0, 5));
    return k;
  endfunction

  task automatic send_list(input logic [lphsc_pkg::REQ_BITS-1:0] req,
                           input int unsigned count);
    key_t                k;
    logic                last;
    for (int unsigned i = 0; i < count; i++) begin
      k    = pick_key(req == lphsc_pkg::REQ_INSERT ? 20 : 60);
      last = (i == count - 1);
      // A few lists carry a misplaced or missing end mark.
      if ($urandom_range(0, 99) < 8) last = 1'($urandom_range(0, 1));
      send_word(req, k, last);
      random_words++;
      if (req == lphsc_pkg::REQ_INSERT) begin
        live_keys.push_back(k);
        if (live_keys.size() > LIVE_DEPTH) void'(live_keys.pop_front());
      end
    end
  endtask

  initial begin : stimulus
    key_t k;
    key_t probe_key;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = lphsc_pkg::REQ_CLEAR;
    in_tlast     = 1'b0;
    rst_n        = 1'b0;
    calm         = 1'b0;
    random_words = 0;
    cluster_home = '0;
    probe_key    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: key extremes, wraparound, duplicates, spare code, a missed query.
    send_word(lphsc_pkg::REQ_CLEAR, '1, 1'b1);
    send_word(lphsc_pkg::REQ_INSERT, '0, 1'b0);
    send_word(lphsc_pkg::REQ_INSERT, '1, 1'b0);
    send_word(lphsc_pkg::REQ_INSERT, key_t'(lphsc_pkg::TABLE_SLOTS - 1), 1'b0);
    send_word(lphsc_pkg::REQ_INSERT, '1, 1'b1);
    send_word(REQ_SPARE, '1, 1'b1);
    send_word(lphsc_pkg::REQ_QUERY, '1, 1'b0);
    send_word(lphsc_pkg::REQ_QUERY, key_t'(lphsc_pkg::TABLE_SLOTS - 1), 1'b0);
    send_word(lphsc_pkg::REQ_QUERY, '0, 1'b0);
    send_word(lphsc_pkg::REQ_QUERY, key_t'(lphsc_pkg::TABLE_SLOTS), 1'b1);
    send_word(lphsc_pkg::REQ_QUERY, '0, 1'b1);
    send_word(REQ_SPARE, '0, 1'b0);
    wait_drain();
    send_word(lphsc_pkg::REQ_CLEAR, '0, 1'b0);
    send_word(lphsc_pkg::REQ_INSERT, 31'h2AAA_AAAA, 1'b0);
    send_word(lphsc_pkg::REQ_INSERT, 31'h5555_5555, 1'b1);
    send_word(lphsc_pkg::REQ_CLEAR, 31'h5555_5555, 1'b1);
    send_word(lphsc_pkg::REQ_QUERY, 31'h2AAA_AAAA, 1'b1);

    // Build one long cluster on a single home that wraps past the last slot,
    // then probe deep into it with a hit and with a miss.
    send_word(lphsc_pkg::REQ_CLEAR, key_t'($urandom), 1'b0);
    for (int unsigned s = 0; s < CHAIN_WORDS; s++) begin
      k = key_t'($urandom);
      k[lphsc_pkg::SLOT_BITS-1:0] = slot_t'(lphsc_pkg::TABLE_SLOTS - 20);
      if (s == CHAIN_WORDS - 3) probe_key = k;
      send_word(lphsc_pkg::REQ_INSERT, k, s == CHAIN_WORDS - 1);
    end
    send_word(lphsc_pkg::REQ_INSERT, key_t'($urandom), 1'b1);
    send_word(lphsc_pkg::REQ_QUERY, probe_key, 1'b0);
    send_word(lphsc_pkg::REQ_QUERY, probe_key ^ (31'd1 << 30), 1'b1);
    send_word(REQ_SPARE, key_t'($urandom), 1'b1);
    wait_drain();
    send_word(lphsc_pkg::REQ_CLEAR, key_t'($urandom), 1'b0);

    // Random sets and subset tests.
    while (random_words < RANDOM_WORDS) begin
      calm = (random_words >= 500 && random_words < 800);
      cluster_home = ($urandom_range(0, 3) == 0) ? slot_t'(lphsc_pkg::TABLE_SLOTS - 3)
                                                 : slot_t'($urandom);
      if ($urandom_range(0, 99) < 18) begin
        send_word(lphsc_pkg::REQ_CLEAR, key_t'($urandom), 1'($urandom_range(0, 1)));
        live_keys.delete();
        random_words++;
      end
      if ($urandom_range(0, 99) < 6)
        repeat ($urandom_range(1, 3))
          send_word(REQ_SPARE, key_t'($urandom), 1'($urandom_range(0, 1)));
      send_list(lphsc_pkg::REQ_INSERT, $urandom_range(1, 20));
      send_list(lphsc_pkg::REQ_QUERY, $urandom_range(0, 20));
      if ($urandom_range(0, 19) == 0) wait_drain();
    end
    calm = 1'b0;

    wait_drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
